// ----- rtl/sha_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions of the SHA-256 hash core.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned WordW     = 32;
    localparam int unsigned CountW    = 61;
    localparam int unsigned QueueDepth = 4;

    localparam logic [31:0] PadWord = 32'h8000_0000;

    // Kinds of words that the front hands to the back.
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_LEN  = 2'd1,
        KIND_LAST = 2'd2
    } t_kind;

    // One queue entry: a finished block word and what it means.
    typedef struct packed {
        logic [31:0] word;
        t_kind       kind;
    } t_qword;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sha_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;

    modport source (output valid, data_word, valid_bytes, end_of_message, input ready);
    modport sink   (input valid, data_word, valid_bytes, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/sha256_hash_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hash core
// Streams message words in, hashes them and streams the digest out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one message word per beat, first byte in bits 31..24.
//   valid_bytes counts the bytes of the word that belong to the message; only
//   the beat with end_of_message set may hold fewer than four.
//   out_ch delivers eight digest beats, word_index 0 to 7, last_word on the
//   eighth, after each beat that ends a message.
//   A front end counts bytes and emits padded block words into a four-entry
//   queue; the engine shifts sixteen words in, then runs 64 rounds at one per
//   cycle and then the chain update. It takes no words while it runs the
//   rounds, so the round loop sets the sustained rate. Padding fills the last
//   block and adds one more block when the length words do not fit in it.
//   The first digest beat follows the chain update of the block that holds
//   the length words; the other seven beats follow one per cycle when the
//   receiver is ready.
//   Reset clears counters and loads the initial hash; no clearing pass.
//   A stall on out_ch holds the digest beat and backs up the queue and input.
// ----------------------------------------------------------------------------
module sha256_hash_core #(
    parameter int unsigned QDepth = sha_pkg::QueueDepth
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sha_in_if.sink      in_ch,
    sha_out_if.source   out_ch
);
    import sha_pkg::*;

    t_qword  f_word, q_word;
    logic    f_valid, q_ready, q_valid, q_pop;

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_word(f_word), .o_word_valid(f_valid), .i_word_ready(q_ready)
    );

    sha_queue #(.Depth(QDepth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_word(f_word), .i_push(f_valid), .o_ready(q_ready),
        .o_word(q_word), .o_valid(q_valid), .i_pop(q_pop)
    );

    sha_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_word(q_word), .i_word_valid(q_valid), .o_word_pop(q_pop),
        .out_ch(out_ch)
    );

endmodule
`default_nettype wire

// ----- rtl/sha_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts message beats, counts bytes and emits padded block words.
// ----------------------------------------------------------------------------
module sha_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sha_in_if.sink             in_ch,
    output sha_pkg::t_qword    o_word,
    output logic               o_word_valid,
    input  wire logic          i_word_ready
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_TAKE = 3'b001,
        S_PAD  = 3'b010,
        S_LEN  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CountW-1:0]   r_bytes, n_bytes;
    logic [3:0]          r_slot, n_slot;
    logic                r_lenlo, n_lenlo;
    logic [2:0]          nb;
    logic [31:0]         keep, padded;
    logic [63:0]         bits;

    assign nb = (in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;
    assign bits = {r_bytes, 3'b000};

    // Mask off bytes past the count and place the pad byte right after them.
    always_comb begin
        case (nb)
            3'd0: begin keep = 32'h0000_0000; padded = 32'h8000_0000; end
            3'd1: begin keep = 32'hff00_0000; padded = 32'h0080_0000; end
            3'd2: begin keep = 32'hffff_0000; padded = 32'h0000_8000; end
            3'd3: begin keep = 32'hffff_ff00; padded = 32'h0000_0080; end
            default: begin keep = 32'hffff_ffff; padded = 32'h0000_0000; end
        endcase
    end

    // Word generator: one word per queue beat.
    always_comb begin
        n_state = r_state;
        n_bytes = r_bytes;
        n_slot = r_slot;
        n_lenlo = r_lenlo;
        in_ch.ready = 1'b0;
        o_word_valid = 1'b0;
        o_word = '{word: 32'h0, kind: KIND_DATA};
        case (r_state)
            S_TAKE: begin
                in_ch.ready = i_word_ready;
                o_word_valid = in_ch.valid;
                if (!in_ch.end_of_message) begin
                    o_word.word = in_ch.data_word;
                end else begin
                    o_word.word = (in_ch.data_word & keep) | padded;
                end
                if (in_ch.valid && i_word_ready) begin
                    n_slot = r_slot + 4'd1;
                    if (!in_ch.end_of_message) begin
                        n_bytes = r_bytes + CountW'(4);
                    end else begin
                        n_bytes = r_bytes + CountW'(nb);
                        if (nb == 3'd4) begin
                            n_state = S_PAD;
                        end else if (r_slot == 4'd13) begin
                            n_state = S_LEN;
                            n_lenlo = 1'b0;
                        end else begin
                            n_state = S_PAD;
                        end
                    end
                end
            end
            S_PAD: begin
                o_word_valid = 1'b1;
                o_word.word = r_lenlo ? 32'h0 : PadWord;
                if (i_word_ready) begin
                    n_slot = r_slot + 4'd1;
                    n_lenlo = 1'b1;
                    if (r_slot == 4'd13) begin
                        n_state = S_LEN;
                        n_lenlo = 1'b0;
                    end
                end
            end
            S_LEN: begin
                o_word_valid = 1'b1;
                o_word.word = r_lenlo ? bits[31:0] : bits[63:32];
                o_word.kind = r_lenlo ? KIND_LAST : KIND_LEN;
                if (i_word_ready) begin
                    n_slot = r_slot + 4'd1;
                    n_lenlo = 1'b1;
                    if (r_lenlo) begin
                        n_state = S_TAKE;
                        n_bytes = '0;
                        n_slot = 4'd0;
                    end
                end
            end
            default: n_state = S_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_bytes <= '0;
            r_slot <= 4'd0;
            r_lenlo <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bytes <= n_bytes;
            r_slot <= n_slot;
            // The pad state starts with the pad word only when a full word ended.
            if (r_state == S_TAKE && n_state == S_PAD) begin
                r_lenlo <= (nb != 3'd4);
            end else begin
                r_lenlo <= n_lenlo;
            end
        end
    end

`ifndef SYNTHESIS
    // The length words always land in slots 14 and 15.
    a_len_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |-> (r_slot == 4'd14 || r_slot == 4'd15))
        else $error("length word out of place");
    // Input is never taken while padding is in progress.
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_TAKE) |-> !in_ch.ready)
        else $error("input taken during padding");
    // The last word closes the message and clears the count.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN && r_lenlo && i_word_ready) |=> (r_bytes == '0 && r_slot == 4'd0))
        else $error("count not cleared");
`endif

endmodule
`default_nettype wire

// ----- rtl/sha_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Short FIFO between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sha_queue #(
    parameter int unsigned Depth = sha_pkg::QueueDepth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  sha_pkg::t_qword    i_word,
    input  wire logic          i_push,
    output logic               o_ready,
    output sha_pkg::t_qword    o_word,
    output logic               o_valid,
    input  wire logic          i_pop
);
    import sha_pkg::*;

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    t_qword          r_mem [Depth];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            do_push, do_pop;

    assign o_ready = (r_cnt != (AW+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_word = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop = i_pop && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sha_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Loads block words, runs 64 rounds and emits the digest.
// ----------------------------------------------------------------------------
module sha_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  sha_pkg::t_qword    i_word,
    input  wire logic          i_word_valid,
    output logic               o_word_pop,
    sha_out_if.source          out_ch
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        E_LOAD  = 4'b0001,
        E_ROUND = 4'b0010,
        E_ADD   = 4'b0100,
        E_OUT   = 4'b1000
    } t_estate;

    t_estate       r_state;
    logic [31:0]   r_w [16];
    logic [31:0]   r_h [8];
    logic [31:0]   r_v [8];
    logic [3:0]    r_slot;
    logic [5:0]    r_rnd;
    logic          r_final;
    logic [2:0]    r_oidx;
    logic [31:0]   w_new, t1, t2, w_cur;

    assign o_word_pop = (r_state == E_LOAD) && i_word_valid;
    assign w_cur = r_w[0];
    assign w_new = sig1(r_w[14]) + r_w[9] + sig0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + RoundK[r_rnd] + w_cur;
    assign t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign out_ch.valid = (r_state == E_OUT);
    assign out_ch.digest_word = r_h[r_oidx];
    assign out_ch.word_index = r_oidx;
    assign out_ch.last_word = (r_oidx == 3'd7);

    // Message schedule: a sixteen-word shift line.
    always_ff @(posedge i_clk) begin
        if (o_word_pop) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= i_word.word;
        end else if (r_state == E_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    // Round variables.
    always_ff @(posedge i_clk) begin
        if (r_state == E_LOAD && o_word_pop && r_slot == 4'd15) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (r_state == E_ROUND) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    // Control and chain value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_LOAD;
            r_slot <= 4'd0;
            r_rnd <= 6'd0;
            r_final <= 1'b0;
            r_oidx <= 3'd0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
        end else begin
            case (r_state)
                E_LOAD: begin
                    if (o_word_pop) begin
                        r_slot <= r_slot + 4'd1;
                        if (r_slot == 4'd15) begin
                            r_state <= E_ROUND;
                            r_rnd <= 6'd0;
                            r_final <= (i_word.kind == KIND_LAST);
                        end
                    end
                end
                E_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= E_ADD;
                end
                E_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oidx <= 3'd0;
                    r_state <= r_final ? E_OUT : E_LOAD;
                end
                E_OUT: begin
                    if (out_ch.ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_state <= E_LOAD;
                            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
                        end
                    end
                end
                default: r_state <= E_LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    // Words are taken only while loading.
    a_pop_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word_pop |-> (r_state == E_LOAD))
        else $error("word popped outside load");
    // A round run always lasts into the chain update.
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_ROUND && r_rnd == 6'd63) |=> (r_state == E_ADD))
        else $error("round count broken");
    // The final digest beat restores the initial hash.
    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_OUT && out_ch.ready && r_oidx == 3'd7) |=> (r_h[0] == InitHash[0]))
        else $error("chain not reinitialized");
`endif

endmodule
`default_nettype wire
